/* design/trilinear_voxel_splat_accumulator_core_defines.svh */
// Assertion macros shared by the voxel splat accumulator RTL
`ifndef TRILINEAR_VOXEL_SPLAT_ACCUMULATOR_CORE_DEFINES_SVH
`define TRILINEAR_VOXEL_SPLAT_ACCUMULATOR_CORE_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define TVSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define TVSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/tvsa_pkg.sv */
// Package: types, constants and codes of the voxel splat accumulator
package tvsa_pkg;

  localparam int GridXDef = 32;
  localparam int GridYDef = 32;
  localparam int GridZDef = 32;
  localparam logic [26:0] OffsetSixteenths = 27'd1906720;
  localparam logic [12:0] SegSizeReset = 13'd50;
  localparam int CntW = 26;

  localparam logic CmdSplat = 1'b0;
  localparam logic CmdRead  = 1'b1;

  localparam logic [1:0] RegSegSize = 2'd0;
  localparam logic [1:0] RegOccMode = 2'd1;

  typedef struct packed {
    logic        cmd;
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [21:0] pos_z;
    logic [15:0] area_value;
    logic [15:0] intensity_value;
    logic [4:0]  voxel_x;
    logic [4:0]  voxel_y;
    logic [4:0]  voxel_z;
  } in_item_t;

  typedef struct packed {
    logic [47:0] sum_area;
    logic [47:0] sum_intensity;
    logic [31:0] sum_weight;
    logic        occupied;
    logic [3:0]  dropped_corners;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_DIV, ST_CORNER, ST_WMUL, ST_RD,
    ST_ACC, ST_WR, ST_RREAD, ST_RWAIT, ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic div_start;
    logic corner_eval;
    logic wmul;
    logic mem_rd;
    logic acc;
    logic mem_wr;
    logic next_corner;
    logic rread;
    logic emit;
    logic clr_wr;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic corner_in;
    logic last_corner;
    logic clr_last;
    logic is_read;
    logic occ_mode;
  } sts_t;

  localparam logic [2:0] CornerDx [8] = '{3'd0,3'd0,3'd1,3'd1,3'd0,3'd0,3'd1,3'd1};
  localparam logic [2:0] CornerDy [8] = '{3'd0,3'd1,3'd0,3'd1,3'd0,3'd1,3'd0,3'd1};
  localparam logic [2:0] CornerDz [8] = '{3'd0,3'd0,3'd0,3'd0,3'd1,3'd1,3'd1,3'd1};

endpackage

/* design/trilinear_voxel_splat_accumulator_core.sv */
// Top level of the trilinear voxel splat accumulator
// A request is taken when start is high and busy is low; its result shows
// for one cycle with out_valid, and cannot be held off. After reset the
// voxel stores are swept clear, one entry a cycle, over all
// GRID_X*GRID_Y*GRID_Z entries (32768 by default) with busy high. A read
// passes through the load, read-address and wait states before its result
// is emitted. A splat runs the 44-step three-lane divider, then for each
// corner inside the grid evaluates, weights, reads, accumulates and writes
// on the single-port store (no read or accumulate in occupancy mode; a dropped corner is only evaluated and weighted).
module trilinear_voxel_splat_accumulator_core #(
  parameter int GRID_X = tvsa_pkg::GridXDef,
  parameter int GRID_Y = tvsa_pkg::GridYDef,
  parameter int GRID_Z = tvsa_pkg::GridZDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tvsa_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tvsa_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_wdata
);
  tvsa_pkg::ctl_t ctl;
  tvsa_pkg::sts_t sts;

  tvsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl));

  tvsa_datapath #(.GridX(GRID_X), .GridY(GRID_Y), .GridZ(GRID_Z)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .cfg_index(cfg_index),
    .out_item(out_item), .out_strobe(out_valid));
endmodule

/* design/tvsa_ram.sv */
// Generic single-port RAM with registered read
module tvsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // write one entry when we is set; read every cycle (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end
  assign rdata = rdata_r;
endmodule

/* design/tvsa_divider.sv */
// Three-lane restoring divider: cell index and Q0.16 fraction per axis
module tvsa_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [42:0] px,
  input  logic [42:0] py,
  input  logic [42:0] pz,
  input  logic [16:0] dvs,
  output logic        done,
  output logic [43:0] qx,
  output logic [43:0] qy,
  output logic [43:0] qz
);
  // dividend is P shifted left 16: quotient holds cell above fraction
  localparam int NW = 44;
  logic [NW-1:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [17:0]   rx_r, ry_r, rz_r, rx_nxt, ry_nxt, rz_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;

  function automatic logic [17:0] stepr(input logic [17:0] r, input logic b,
                                        input logic [16:0] d, output logic q);
    logic [18:0] t;
    t = {r, b};
    if (t >= {2'b0, d}) begin
      q = 1'b1;
      return 18'(t - {2'b0, d});
    end
    q = 1'b0;
    return t[17:0];
  endfunction

  // one quotient bit per lane per cycle
  always_comb begin
    logic q0, q1, q2;
    nx_nxt = nx_r; ny_nxt = ny_r; nz_nxt = nz_r;
    rx_nxt = rx_r; ry_nxt = ry_r; rz_nxt = rz_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    q0 = 1'b0; q1 = 1'b0; q2 = 1'b0;
    if (start) begin
      nx_nxt = {1'b0, px};
      ny_nxt = {1'b0, py};
      nz_nxt = {1'b0, pz};
      rx_nxt = '0; ry_nxt = '0; rz_nxt = '0;
      cnt_nxt = 6'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rx_nxt = stepr(rx_r, nx_r[NW-1], dvs, q0);
      ry_nxt = stepr(ry_r, ny_r[NW-1], dvs, q1);
      rz_nxt = stepr(rz_r, nz_r[NW-1], dvs, q2);
      nx_nxt = {nx_r[NW-2:0], q0};
      ny_nxt = {ny_r[NW-2:0], q1};
      nz_nxt = {nz_r[NW-2:0], q2};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // hold lane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    nx_r <= nx_nxt; ny_r <= ny_nxt; nz_r <= nz_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; rz_r <= rz_nxt;
  end

  assign done = busy_r && (cnt_r == 6'd1);
  assign qx = nx_nxt;
  assign qy = ny_nxt;
  assign qz = nz_nxt;
endmodule

/* design/tvsa_datapath.sv */
// Datapath: coordinate split, corner weights, voxel stores, result register
module tvsa_datapath #(
  parameter int GridX = tvsa_pkg::GridXDef,
  parameter int GridY = tvsa_pkg::GridYDef,
  parameter int GridZ = tvsa_pkg::GridZDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tvsa_pkg::ctl_t     ctl,
  output tvsa_pkg::sts_t     sts,
  input  tvsa_pkg::in_item_t in_item,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_wdata,
  input  logic [1:0]         cfg_index,
  output tvsa_pkg::out_item_t out_item,
  output logic               out_strobe
);
  localparam int Cells = GridX * GridY * GridZ;
  localparam int AW = $clog2(Cells);
  localparam int XW = $clog2(GridX);
  localparam int YW = $clog2(GridY);
  localparam int ZW = $clog2(GridZ);
  localparam int CW = tvsa_pkg::CntW + 2;

  logic [12:0] seg_r;
  logic        occ_r;
  tvsa_pkg::in_item_t item_r;
  logic [43:0] qx, qy, qz;
  logic [43:0] qxs, qys;
  logic        div_done;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic [16:0] fx_r, fy_r, fz_r;
  logic [2:0]  k_r;
  logic [3:0]  drop_r;
  logic [AW-1:0] addr_r, clr_r;
  logic        cin_r;
  logic [33:0] wxy_r;
  logic [16:0] wz_r;
  logic [16:0] w_r;
  logic [47:0] ta_r, ti_r;
  logic [47:0] na_r, ni_r;
  logic [31:0] nw_r;
  logic [47:0] ra, ri;
  logic [31:0] rw;
  logic        ro;
  tvsa_pkg::out_item_t out_r;
  logic        strobe_r;
  logic [26:0] px, py, pz;
  logic [42:0] nx_d, ny_d, nz_d;
  logic [16:0] dvs;
  logic        read_in_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= tvsa_pkg::SegSizeReset;
      occ_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == tvsa_pkg::RegSegSize) begin
        seg_r <= cfg_wdata;
      end else if (cfg_index == tvsa_pkg::RegOccMode) begin
        occ_r <= cfg_wdata[0];
      end
    end
  end

  assign dvs = {(seg_r == 13'd0) ? 13'd1 : seg_r, 4'd0};
  assign px = 27'(signed'(item_r.pos_x)) + tvsa_pkg::OffsetSixteenths;
  assign py = 27'(signed'(item_r.pos_y)) + tvsa_pkg::OffsetSixteenths;
  assign pz = {5'd0, item_r.pos_z};

  // negative dividend: divide its complement, complement the quotient (floor)
  assign nx_d = px[26] ? {~px, 16'hFFFF} : {px, 16'd0};
  assign ny_d = py[26] ? {~py, 16'hFFFF} : {py, 16'd0};
  assign nz_d = {pz, 16'd0};
  assign qxs = qx ^ {44{px[26]}};
  assign qys = qy ^ {44{py[26]}};

  tvsa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
    .px(nx_d), .py(ny_d), .pz(nz_d), .dvs(dvs),
    .done(div_done), .qx(qx), .qy(qy), .qz(qz)
  );

  // latch request and split results
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_item;
    end
    if (div_done) begin
      // X and Y may be negative: cell is the signed upper part of the quotient
      cx_r <= CW'(signed'(qxs[43:16]));
      cy_r <= CW'(signed'(qys[43:16]));
      cz_r <= CW'(signed'(qz[43:16]));
      fx_r <= {1'b0, qxs[15:0]};
      fy_r <= {1'b0, qys[15:0]};
      fz_r <= {1'b0, qz[15:0]};
    end
  end

  // corner evaluation: index, bounds, first weight product
  always_ff @(posedge clk) begin
    logic signed [CW:0] x, y, z;
    logic [16:0] wx, wy;
    if (!rst_n) begin
      k_r <= '0;
      drop_r <= '0;
      cin_r <= 1'b0;
    end else begin
      if (ctl.div_start) begin
        k_r <= '0;
        drop_r <= '0;
      end
      if (ctl.next_corner) begin
        k_r <= k_r + 3'd1;
      end
      if (ctl.corner_eval) begin
        x = (CW+1)'(cx_r) + (CW+1)'(tvsa_pkg::CornerDx[k_r]);
        y = (CW+1)'(cy_r) + (CW+1)'(tvsa_pkg::CornerDy[k_r]);
        z = (CW+1)'(cz_r) + (CW+1)'(tvsa_pkg::CornerDz[k_r]);
        wx = tvsa_pkg::CornerDx[k_r][0] ? fx_r : 17'(17'h10000 - fx_r);
        wy = tvsa_pkg::CornerDy[k_r][0] ? fy_r : 17'(17'h10000 - fy_r);
        wz_r <= tvsa_pkg::CornerDz[k_r][0] ? fz_r : 17'(17'h10000 - fz_r);
        wxy_r <= wx * wy;
        if (x < 0 || x >= GridX || y < 0 || y >= GridY || z < 0 || z >= GridZ) begin
          cin_r <= 1'b0;
          drop_r <= drop_r + 4'd1;
        end else begin
          cin_r <= 1'b1;
          addr_r <= AW'((z[ZW-1:0] * GridY + y[YW-1:0]) * GridX + x[XW-1:0]);
        end
      end else if (ctl.rread) begin
        addr_r <= AW'((item_r.voxel_z * GridY + item_r.voxel_y) * GridX + item_r.voxel_x);
      end
    end
  end

  // read outside grid returns zeros
  always_ff @(posedge clk) begin
    if (ctl.rread) begin
      read_in_r <= (item_r.voxel_x < GridX) && (item_r.voxel_y < GridY)
                   && (item_r.voxel_z < GridZ);
    end
  end

  // second weight product, then value terms
  always_ff @(posedge clk) begin
    logic [50:0] p;
    if (ctl.wmul) begin
      p = wxy_r * wz_r;
      w_r <= p[48:32];
    end
    if (ctl.mem_rd) begin
      ta_r <= {32'd0, item_r.area_value} * {31'd0, w_r};
      ti_r <= {32'd0, item_r.intensity_value} * {31'd0, w_r};
    end
  end

  // saturating sums
  always_ff @(posedge clk) begin
    logic [48:0] sa, si;
    logic [32:0] sw;
    if (ctl.acc) begin
      sa = {1'b0, ra} + {1'b0, ta_r};
      si = {1'b0, ri} + {1'b0, ti_r};
      sw = {1'b0, rw} + {16'd0, w_r};
      na_r <= sa[48] ? '1 : sa[47:0];
      ni_r <= si[48] ? '1 : si[47:0];
      nw_r <= sw[32] ? '1 : sw[31:0];
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (ctl.clr_wr) begin
      clr_r <= clr_r + 1'b1;
    end
  end

  logic [AW-1:0] maddr;
  logic we_sum, we_occ;
  logic [47:0] wa, wi;
  logic [31:0] ww;
  logic        wo;
  assign maddr  = ctl.clr_wr ? clr_r : addr_r;
  assign we_sum = ctl.clr_wr || (ctl.mem_wr && !occ_r);
  assign we_occ = ctl.clr_wr || (ctl.mem_wr && occ_r);
  assign wa = ctl.clr_wr ? '0 : na_r;
  assign wi = ctl.clr_wr ? '0 : ni_r;
  assign ww = ctl.clr_wr ? '0 : nw_r;
  assign wo = !ctl.clr_wr;

  tvsa_ram #(.Width(48), .Depth(Cells)) u_area (
    .clk(clk), .we(we_sum), .addr(maddr), .wdata(wa), .rdata(ra));
  tvsa_ram #(.Width(48), .Depth(Cells)) u_inten (
    .clk(clk), .we(we_sum), .addr(maddr), .wdata(wi), .rdata(ri));
  tvsa_ram #(.Width(32), .Depth(Cells)) u_weight (
    .clk(clk), .we(we_sum), .addr(maddr), .wdata(ww), .rdata(rw));
  tvsa_ram #(.Width(1), .Depth(Cells)) u_occ (
    .clk(clk), .we(we_occ), .addr(maddr), .wdata(wo), .rdata(ro));

  // result register
  always_ff @(posedge clk) begin
    tvsa_pkg::out_item_t o;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl.emit;
    end
    if (ctl.emit) begin
      o = '0;
      if (item_r.cmd == tvsa_pkg::CmdRead) begin
        if (read_in_r) begin
          o.sum_area = ra;
          o.sum_intensity = ri;
          o.sum_weight = rw;
          o.occupied = ro;
        end
      end else begin
        o.dropped_corners = drop_r;
      end
      out_r <= o;
    end
  end

  assign out_item = out_r;
  assign out_strobe = strobe_r;

  assign sts.div_done    = div_done;
  assign sts.corner_in   = cin_r;
  assign sts.last_corner = (k_r == 3'd7);
  assign sts.clr_last    = (clr_r == AW'(Cells - 1));
  assign sts.is_read     = (item_r.cmd == tvsa_pkg::CmdRead);
  assign sts.occ_mode    = occ_r;
endmodule

/* design/tvsa_ctrl.sv */
// Controller: sequences clearing sweep, divide, eight corner visits, reads
`include "trilinear_voxel_splat_accumulator_core_defines.svh"
module tvsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  tvsa_pkg::sts_t sts,
  output tvsa_pkg::ctl_t ctl
);
  tvsa_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tvsa_pkg::ST_CLEAR: if (sts.clr_last) state_nxt = tvsa_pkg::ST_IDLE;
      tvsa_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = tvsa_pkg::ST_LOAD;
        end
      end
      tvsa_pkg::ST_LOAD: begin
        state_nxt = sts.is_read ? tvsa_pkg::ST_RREAD : tvsa_pkg::ST_DIV;
      end
      tvsa_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = tvsa_pkg::ST_CORNER;
        end
      end
      tvsa_pkg::ST_CORNER: state_nxt = tvsa_pkg::ST_WMUL;
      tvsa_pkg::ST_WMUL: begin
        if (!sts.corner_in) begin
          state_nxt = sts.last_corner ? tvsa_pkg::ST_DONE : tvsa_pkg::ST_CORNER;
        end else if (sts.occ_mode) begin
          state_nxt = tvsa_pkg::ST_WR;
        end else begin
          state_nxt = tvsa_pkg::ST_RD;
        end
      end
      tvsa_pkg::ST_RD:  state_nxt = tvsa_pkg::ST_ACC;
      tvsa_pkg::ST_ACC: state_nxt = tvsa_pkg::ST_WR;
      tvsa_pkg::ST_WR:  state_nxt = sts.last_corner ? tvsa_pkg::ST_DONE
                                                    : tvsa_pkg::ST_CORNER;
      tvsa_pkg::ST_RREAD: state_nxt = tvsa_pkg::ST_RWAIT;
      tvsa_pkg::ST_RWAIT: state_nxt = tvsa_pkg::ST_DONE;
      tvsa_pkg::ST_DONE:  state_nxt = tvsa_pkg::ST_IDLE;
      default: state_nxt = tvsa_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl = '0;
    busy = 1'b1;
    case (state_r)
      tvsa_pkg::ST_CLEAR: ctl.clr_wr = 1'b1;
      tvsa_pkg::ST_IDLE: begin
        busy = 1'b0;
        ctl.load = start;
      end
      tvsa_pkg::ST_LOAD: ctl.div_start = !sts.is_read;
      tvsa_pkg::ST_CORNER: ctl.corner_eval = 1'b1;
      tvsa_pkg::ST_WMUL: begin
        ctl.wmul = 1'b1;
        ctl.next_corner = !sts.corner_in && !sts.last_corner;
      end
      tvsa_pkg::ST_RD: ctl.mem_rd = 1'b1;
      tvsa_pkg::ST_ACC: ctl.acc = 1'b1;
      tvsa_pkg::ST_WR: begin
        ctl.mem_wr = 1'b1;
        ctl.next_corner = !sts.last_corner;
      end
      tvsa_pkg::ST_RREAD: ctl.rread = 1'b1;
      tvsa_pkg::ST_RWAIT: ctl.rread = 1'b0;
      tvsa_pkg::ST_DONE: ctl.emit = 1'b1;
      default: ctl = '0;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tvsa_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TVSA_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n,
    state_r == tvsa_pkg::ST_IDLE && start, busy)
  `TVSA_ASSERT_IMP(a_emit_only_done, clk, rst_n, ctl.emit, state_r == tvsa_pkg::ST_DONE)
  `TVSA_ASSERT_IMP(a_no_write_while_idle, clk, rst_n, !busy, !ctl.mem_wr && !ctl.clr_wr)
endmodule
